@@ rtl/core/hkinv_pkg.sv @@
// hkinv_pkg: shared types and constants for the 2x2 key matrix inverse block
// no dependencies; used by the remainder unit, controller, datapath and top level
`timescale 1ns / 1ps

package hkinv_pkg;

    // config register reset value
    localparam logic [7:0] MODULUS_RESET = 8'd94;

    // shift-subtract steps of the remainder unit, one per product bit
    localparam int MOD_STEPS = 16;

    // which product the remainder unit reduces
    typedef enum logic [2:0] {
        OP_AD,
        OP_BC,
        OP_XD,
        OP_XB,
        OP_XC,
        OP_XA
    } op_sel_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_WAIT,
        S_SINIT,
        S_SEARCH,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_key;
        logic    mod_start;
        op_sel_t op;
        logic    search_init;
        logic    search_step;
        logic    load_out;
        logic    fail;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mod_small;
        logic mod_busy;
        logic mod_done;
        logic found;
        logic x_last;
    } dp_sts_t;

endpackage

@@ rtl/core/hkinv_modred.sv @@
// hkinv_modred: serial remainder of a 16-bit product by an 8-bit modulus
// one restoring shift-subtract step per cycle; uses hkinv_pkg
`timescale 1ns / 1ps

module hkinv_modred (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] value,
    input  logic [7:0]  modulus,
    output logic        busy,
    output logic        done,
    output logic [7:0]  rem
);

    localparam int CNT_BITS = $clog2(hkinv_pkg::MOD_STEPS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(hkinv_pkg::MOD_STEPS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]         div_reg, div_next;
    logic [7:0]          rem_reg, rem_next;
    logic [8:0]          trial;
    logic [8:0]          mod_ext;

    // load the operand on start, else one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        mod_ext   = {1'b0, modulus};
        trial     = {rem_reg, div_reg[15]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = value;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            div_next = {div_reg[14:0], 1'b0};
            if (trial >= mod_ext)
            begin
                rem_next = 8'(trial - mod_ext);
            end
            else
            begin
                rem_next = trial[7:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/core/hkinv_datapath.sv @@
// hkinv_datapath: key registers, multiplier, multiplier search and result registers
// depends on hkinv_pkg and hkinv_modred
`timescale 1ns / 1ps

module hkinv_datapath #(
    parameter int ENTRY_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic [7:0]         key_a,
    input  logic [7:0]         key_b,
    input  logic [7:0]         key_c,
    input  logic [7:0]         key_d,
    input  hkinv_pkg::dp_cmd_t cmd,
    output hkinv_pkg::dp_sts_t sts,
    output logic [7:0]         inv_a,
    output logic [7:0]         inv_b,
    output logic [7:0]         inv_c,
    output logic [7:0]         inv_d,
    output logic               not_invertible
);

    localparam int KEEP_BITS = (ENTRY_BITS < 8) ? ENTRY_BITS : 8;
    localparam logic [7:0] ENTRY_MASK = 8'((1 << KEEP_BITS) - 1);

    logic [7:0]         modulus_reg;
    logic [7:0]         a_reg, b_reg, c_reg, d_reg;
    logic [7:0]         p_reg, det_reg, det_next;
    logic [7:0]         x_reg, r_reg, r_next;
    logic [7:0]         ra_reg, rb_reg, rc_reg, rd_reg;
    logic [7:0]         neg_rem;
    hkinv_pkg::op_sel_t op_reg;
    logic [7:0]         opnd_x, opnd_y;
    logic [15:0]        product;
    logic [8:0]         diff_sum;
    logic [8:0]         step_sum;
    logic               mod_busy, mod_done;
    logic [7:0]         mod_rem;

    // modulus config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= hkinv_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // multiplier operand select
    always_comb
    begin
        case (cmd.op)
            hkinv_pkg::OP_AD: begin opnd_x = a_reg; opnd_y = d_reg; end
            hkinv_pkg::OP_BC: begin opnd_x = b_reg; opnd_y = c_reg; end
            hkinv_pkg::OP_XD: begin opnd_x = x_reg; opnd_y = d_reg; end
            hkinv_pkg::OP_XB: begin opnd_x = x_reg; opnd_y = b_reg; end
            hkinv_pkg::OP_XC: begin opnd_x = x_reg; opnd_y = c_reg; end
            hkinv_pkg::OP_XA: begin opnd_x = x_reg; opnd_y = a_reg; end
            default:          begin opnd_x = '0;    opnd_y = '0;    end
        endcase
        product = 16'(opnd_x) * 16'(opnd_y);
    end

    hkinv_modred u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mod_start),
        .value   (product),
        .modulus (modulus_reg),
        .busy    (mod_busy),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // determinant as ad - bc kept in 0..m-1, negation of a residue
    always_comb
    begin
        diff_sum = {1'b0, p_reg} + {1'b0, modulus_reg} - {1'b0, mod_rem};
        if (p_reg >= mod_rem)
        begin
            det_next = p_reg - mod_rem;
        end
        else
        begin
            det_next = diff_sum[7:0];
        end
        neg_rem = (mod_rem == 8'd0) ? 8'd0 : (modulus_reg - mod_rem);
    end

    // running residue det*x mod m, one add and compare per step
    always_comb
    begin
        step_sum = {1'b0, r_reg} + {1'b0, det_reg};
        if (step_sum >= {1'b0, modulus_reg})
        begin
            r_next = 8'(step_sum - {1'b0, modulus_reg});
        end
        else
        begin
            r_next = step_sum[7:0];
        end
    end

    // key capture, search registers and product residues
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            a_reg <= key_a & ENTRY_MASK;
            b_reg <= key_b & ENTRY_MASK;
            c_reg <= key_c & ENTRY_MASK;
            d_reg <= key_d & ENTRY_MASK;
        end
        if (cmd.mod_start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.search_init)
        begin
            x_reg <= 8'd1;
            r_reg <= det_reg;
        end
        else if (cmd.search_step)
        begin
            x_reg <= x_reg + 8'd1;
            r_reg <= r_next;
        end
        if (mod_done)
        begin
            case (op_reg)
                hkinv_pkg::OP_AD: p_reg   <= mod_rem;
                hkinv_pkg::OP_BC: det_reg <= det_next;
                hkinv_pkg::OP_XD: ra_reg  <= mod_rem;
                hkinv_pkg::OP_XB: rb_reg  <= neg_rem;
                hkinv_pkg::OP_XC: rc_reg  <= neg_rem;
                hkinv_pkg::OP_XA: rd_reg  <= mod_rem;
                default:          p_reg   <= p_reg;
            endcase
        end
    end

    // output register, zeros with the flag for a key with no inverse
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            inv_a          <= cmd.fail ? 8'd0 : ra_reg;
            inv_b          <= cmd.fail ? 8'd0 : rb_reg;
            inv_c          <= cmd.fail ? 8'd0 : rc_reg;
            inv_d          <= cmd.fail ? 8'd0 : rd_reg;
            not_invertible <= cmd.fail;
        end
    end

    // status back to the controller
    assign sts.mod_small = (modulus_reg < 8'd2);
    assign sts.mod_busy  = mod_busy;
    assign sts.mod_done  = mod_done;
    assign sts.found     = (r_reg == 8'd1);
    assign sts.x_last    = (x_reg == modulus_reg - 8'd1);

endmodule

@@ rtl/core/hkinv_ctrl.sv @@
// hkinv_ctrl: sequencer for products, multiplier search and output transfer
// depends on hkinv_pkg; drives hkinv_datapath through dp_cmd_t
`timescale 1ns / 1ps

module hkinv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  hkinv_pkg::dp_sts_t sts,
    output hkinv_pkg::dp_cmd_t cmd
);

    hkinv_pkg::state_t  state_reg, state_next;
    hkinv_pkg::op_sel_t op_reg, op_next;
    logic               fail_reg, fail_next;
    logic               out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        fail_next       = fail_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.fail        = fail_reg;
        case (state_reg)
            hkinv_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    if (sts.mod_small)
                    begin
                        fail_next  = 1'b1;
                        state_next = hkinv_pkg::S_FINISH;
                    end
                    else
                    begin
                        fail_next  = 1'b0;
                        op_next    = hkinv_pkg::OP_AD;
                        state_next = hkinv_pkg::S_MUL;
                    end
                end
            end
            hkinv_pkg::S_MUL:
            begin
                cmd.mod_start = 1'b1;
                state_next    = hkinv_pkg::S_WAIT;
            end
            hkinv_pkg::S_WAIT:
            begin
                if (sts.mod_done)
                begin
                    case (op_reg)
                        hkinv_pkg::OP_BC: state_next = hkinv_pkg::S_SINIT;
                        hkinv_pkg::OP_XA: state_next = hkinv_pkg::S_FINISH;
                        hkinv_pkg::OP_AD:
                        begin
                            op_next    = hkinv_pkg::OP_BC;
                            state_next = hkinv_pkg::S_MUL;
                        end
                        hkinv_pkg::OP_XD:
                        begin
                            op_next    = hkinv_pkg::OP_XB;
                            state_next = hkinv_pkg::S_MUL;
                        end
                        hkinv_pkg::OP_XB:
                        begin
                            op_next    = hkinv_pkg::OP_XC;
                            state_next = hkinv_pkg::S_MUL;
                        end
                        hkinv_pkg::OP_XC:
                        begin
                            op_next    = hkinv_pkg::OP_XA;
                            state_next = hkinv_pkg::S_MUL;
                        end
                        default: state_next = hkinv_pkg::S_IDLE;
                    endcase
                end
            end
            hkinv_pkg::S_SINIT:
            begin
                cmd.search_init = 1'b1;
                state_next      = hkinv_pkg::S_SEARCH;
            end
            hkinv_pkg::S_SEARCH:
            begin
                if (sts.found)
                begin
                    op_next    = hkinv_pkg::OP_XD;
                    state_next = hkinv_pkg::S_MUL;
                end
                else if (sts.x_last)
                begin
                    fail_next  = 1'b1;
                    state_next = hkinv_pkg::S_FINISH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            hkinv_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = hkinv_pkg::S_IDLE;
                end
            end
            default: state_next = hkinv_pkg::S_IDLE;
        endcase
    end

    // output valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkinv_pkg::S_IDLE;
            op_reg        <= hkinv_pkg::OP_AD;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending output");

    // the remainder unit is only started when free
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_start |-> !sts.mod_busy)
        else $error("remainder unit restarted while busy");

    // a remainder completes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mod_done |-> (state_reg == hkinv_pkg::S_WAIT))
        else $error("remainder done outside wait state");

    // an input transfer always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != hkinv_pkg::S_IDLE))
        else $error("accepted key left the sequencer idle");

endmodule

@@ rtl/core/hill_key_inverse_2x2_mod.sv @@
// 2x2 key matrix inverse modulo a configured modulus
// one key at a time: an invertible key takes six serial remainders and one search step per
// candidate multiplier up to the one found; a key with no inverse stops after the determinant
// and a search over every candidate; a modulus below two goes straight to the result, which
// is flagged as not invertible; the result may be held off by out_ready, and the next key is
// taken while a result waits; reset: rst_n asynchronous active low, modulus returns to 94,
// no result pending
`timescale 1ns / 1ps

module hill_key_inverse_2x2_mod #(
    parameter int ENTRY_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] key_a,
    input  logic [7:0] key_b,
    input  logic [7:0] key_c,
    input  logic [7:0] key_d,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] inv_a,
    output logic [7:0] inv_b,
    output logic [7:0] inv_c,
    output logic [7:0] inv_d,
    output logic       not_invertible
);

    hkinv_pkg::dp_cmd_t cmd;
    hkinv_pkg::dp_sts_t sts;

    // sequencer
    hkinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and result registers
    hkinv_datapath #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .key_a          (key_a),
        .key_b          (key_b),
        .key_c          (key_c),
        .key_d          (key_d),
        .cmd            (cmd),
        .sts            (sts),
        .inv_a          (inv_a),
        .inv_b          (inv_b),
        .inv_c          (inv_c),
        .inv_d          (inv_d),
        .not_invertible (not_invertible)
    );

endmodule
